// ===== rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and types for the life cell stencil stream.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int unsigned MAX_WIDTH      = 1024;
   localparam int unsigned MAX_HEIGHT     = 4096;
   localparam int unsigned MIN_SIZE       = 3;
   localparam int unsigned COL_BITS       = $clog2(MAX_WIDTH);
   localparam int unsigned WIDTH_BITS     = 11;
   localparam int unsigned HEIGHT_BITS    = 13;
   localparam int unsigned ROW_BITS       = 13;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 13;
   localparam int unsigned WIDTH_RESET    = 800;
   localparam int unsigned HEIGHT_RESET   = 600;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 2'd1;

   // item kinds
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // rule constants
   localparam logic [8:0] NEIGHBOUR_MASK = 9'h1EF;
   localparam logic [3:0] BIRTH_COUNT    = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT  = 4'd2;

   typedef struct packed {
      logic kind;
      logic cell_alive;
   } lcs_req_type;

   typedef struct packed {
      logic next_alive;
      logic frame_end;
   } lcs_rsp_type;

   // one accepted cell on its way to the window
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                v;
      logic                emit;
      logic                border;
      logic                frame_end;
   } lcs_slot_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
   } lcs_rd_type;

   // data bit 0 upper row, bit 1 middle row
   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
      logic [1:0]          data;
   } lcs_wr_type;

endpackage

// ===== rtl/lcs_row_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_row_store
// Two row lines held side by side in one memory, registered read.
// ----------------------------------------------------------------------------
module lcs_row_store (
   input  logic              clock,
   input  lcs_pkg::lcs_rd_type rd,
   input  lcs_pkg::lcs_wr_type wr,
   output logic [1:0]        rd_data
);

   logic [1:0] store_mem [lcs_pkg::MAX_WIDTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= store_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lcs_raster_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_raster_ctl
// Size registers, raster counters and per-cell position decode.
// ----------------------------------------------------------------------------
module lcs_raster_ctl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lcs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 accept,
   input  lcs_pkg::lcs_req_type                 req_word,
   output logic                                 slot_load,
   output lcs_pkg::lcs_slot_type                slot,
   output lcs_pkg::lcs_rd_type                  rd
);

   localparam int unsigned WB = lcs_pkg::WIDTH_BITS;
   localparam int unsigned HB = lcs_pkg::HEIGHT_BITS;
   localparam int unsigned RB = lcs_pkg::ROW_BITS;
   localparam int unsigned CB = lcs_pkg::COL_BITS;

   logic [WB-1:0] grid_width_ff,  grid_width_in;
   logic [HB-1:0] grid_height_ff, grid_height_in;
   logic [CB-1:0] in_column_ff,   in_column_in;
   logic [RB-1:0] in_row_ff,      in_row_in;

   logic [WB-1:0] w_eff;
   logic [HB-1:0] h_eff;
   logic [CB-1:0] c;
   logic [RB-1:0] r;
   logic [WB-1:0] c_next;
   logic [RB-1:0] pr;
   logic [WB-1:0] pc;
   logic          drop;
   logic          emit;
   logic          last;

   // clamped sizes
   always_comb begin
      w_eff = grid_width_ff;
      if (w_eff > WB'(lcs_pkg::MAX_WIDTH)) w_eff = WB'(lcs_pkg::MAX_WIDTH);
      if (w_eff < WB'(lcs_pkg::MIN_SIZE))  w_eff = WB'(lcs_pkg::MIN_SIZE);
      h_eff = grid_height_ff;
      if (h_eff > HB'(lcs_pkg::MAX_HEIGHT)) h_eff = HB'(lcs_pkg::MAX_HEIGHT);
      if (h_eff < HB'(lcs_pkg::MIN_SIZE))   h_eff = HB'(lcs_pkg::MIN_SIZE);
   end

   always_comb begin
      // column left beyond a narrowed row wraps first
      if (WB'(in_column_ff) >= w_eff) begin
         c = '0;
         r = in_row_ff + RB'(1);
      end else begin
         c = in_column_ff;
         r = in_row_ff;
      end

      drop = (req_word.kind == lcs_pkg::KIND_FLUSH) && (r == '0) && (c == '0);
      emit = !((r == '0) || ((r == RB'(1)) && (c == '0)));

      // emitted cell sits one row and one cell behind
      if (c != '0) begin
         pr = r - RB'(1);
         pc = WB'(c) - WB'(1);
      end else begin
         pr = r - RB'(2);
         pc = w_eff - WB'(1);
      end

      last = (pr >= RB'(h_eff)) ||
             ((pr == RB'(h_eff - HB'(1))) && (pc == w_eff - WB'(1)));

      slot.col       = c;
      slot.v         = (req_word.kind == lcs_pkg::KIND_CELL) && (r < RB'(h_eff)) &&
                       req_word.cell_alive;
      slot.emit      = emit;
      slot.border    = (pr == '0) || (pr >= RB'(h_eff - HB'(1))) ||
                       (pc == '0) || (pc == w_eff - WB'(1));
      slot.frame_end = last;

      slot_load = accept && !drop;
      rd.en     = slot_load;
      rd.addr   = c;

      c_next = WB'(c) + WB'(1);
      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      if (slot_load) begin
         if (emit && last) begin
            in_column_in = '0;
            in_row_in    = '0;
         end else if (c_next >= w_eff) begin
            in_column_in = '0;
            in_row_in    = r + RB'(1);
         end else begin
            in_column_in = c_next[CB-1:0];
            in_row_in    = r;
         end
      end
   end

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         case (csr_index)
            lcs_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[WB-1:0];
            lcs_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata[HB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= WB'(lcs_pkg::WIDTH_RESET);
         grid_height_ff <= HB'(lcs_pkg::HEIGHT_RESET);
         in_column_ff   <= '0;
         in_row_ff      <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         in_column_ff   <= in_column_in;
         in_row_ff      <= in_row_in;
      end
   end

endmodule

// ===== rtl/lcs_window_rule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_window_rule
// Row store write-back with forwarding, 3x3 window, B3/S23 rule, output word.
// ----------------------------------------------------------------------------
module lcs_window_rule (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  slot_load,
   input  lcs_pkg::lcs_slot_type slot,
   input  logic [1:0]            rd_data,
   output lcs_pkg::lcs_wr_type   wr,
   output logic                  s1_busy,
   output logic                  s1_go,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output lcs_pkg::lcs_rsp_type  rsp_data
);

   logic                  s1_valid_ff, s1_valid_in;
   lcs_pkg::lcs_slot_type s1_ff;
   logic                  fwd_hit_ff;
   logic [1:0]            fwd_data_ff;
   logic [8:0]            window_ff, window_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lcs_pkg::lcs_rsp_type  rsp_ff, rsp_in;

   logic [1:0] above;
   logic [3:0] count;
   logic       centre;
   logic       next;

   assign s1_go   = s1_valid_ff && (!s1_ff.emit || !rsp_valid_ff || rsp_ready);
   assign s1_busy = s1_valid_ff;

   // last write lands on the edge this read was taken
   assign above = fwd_hit_ff ? fwd_data_ff : rd_data;

   assign wr.en   = s1_go;
   assign wr.addr = s1_ff.col;
   assign wr.data = {s1_ff.v, above[1]};

   always_comb begin
      window_in = {s1_ff.v, above[1], above[0], window_ff[8:3]};
      centre    = window_in[4];
      count     = '0;
      for (int i = 0; i < 9; i++) begin
         if (lcs_pkg::NEIGHBOUR_MASK[i]) count = count + 4'(window_in[i]);
      end
      if (s1_ff.border)                      next = centre;
      else if (count == lcs_pkg::BIRTH_COUNT)   next = 1'b1;
      else if (count == lcs_pkg::SURVIVE_COUNT) next = centre;
      else                                   next = 1'b0;

      rsp_in.next_alive = next;
      rsp_in.frame_end  = s1_ff.frame_end;
   end

   always_comb begin
      if (slot_load)  s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;
      else            s1_valid_in = s1_valid_ff;

      if (s1_go && s1_ff.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_load) begin
         s1_ff       <= slot;
         fwd_hit_ff  <= s1_go && (slot.col == s1_ff.col);
         fwd_data_ff <= {s1_ff.v, above[1]};
      end
      if (s1_go && s1_ff.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/life_cell_stencil_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cell_stencil_stream
// Streaming next-generation engine for the B3/S23 cellular automaton.
// ----------------------------------------------------------------------------
// One cell word is taken per clock while the result side keeps up; the rate
// is set by the row store, a single memory that is read at most once and
// written at most once per cycle. A cell word passes the column decode and
// the memory read on its accepting edge, then the window and rule stage into
// the output register once the window stage moves on. Results trail the
// input stream by one row plus one cell: after the last cell of a frame,
// width + 1 flush words push the pending cells out, the last one marked
// frame_end. The row store has no clearing pass; the first two rows of the
// first frame only feed border cells. The user must write sizes through
// csr_ only while the stream is quiet; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module life_cell_stencil_stream (
   input  logic                               clock,
   input  logic                               reset,
   // cell words in
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lcs_pkg::lcs_req_type               req_data,
   // result words out
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lcs_pkg::lcs_rsp_type               rsp_data,
   // size registers
   input  logic                               csr_we,
   input  logic [lcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lcs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                  accept;
   logic                  slot_load;
   lcs_pkg::lcs_slot_type slot;
   lcs_pkg::lcs_rd_type   rd;
   lcs_pkg::lcs_wr_type   wr;
   logic [1:0]            rd_data;
   logic                  s1_busy;
   logic                  s1_go;

   // window stage free, or moving on this cycle
   assign req_ready = !s1_busy || s1_go;
   assign accept    = req_valid && req_ready;

   // sizes, raster position and border / frame end decode
   lcs_raster_ctl u_raster_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_word  (req_data),
      .slot_load (slot_load),
      .slot      (slot),
      .rd        (rd)
   );

   // the two rows above the incoming column
   lcs_row_store u_row_store (
      .clock   (clock),
      .rd      (rd),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // window shift, neighbour count and output register
   lcs_window_rule u_window_rule (
      .clock     (clock),
      .reset     (reset),
      .slot_load (slot_load),
      .slot      (slot),
      .rd_data   (rd_data),
      .wr        (wr),
      .s1_busy   (s1_busy),
      .s1_go     (s1_go),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/lcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks on the life cell stencil stream, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input lcs_pkg::lcs_rsp_type rsp_data
);

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // an empty output register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with output register empty");

   // a fresh result follows an accepted word through the window stage and output register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without a matching input word");

endmodule

bind life_cell_stencil_stream lcs_checker u_lcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
